// ===== sv/spta_pkg.sv =====
// shared types and constants for the sparse polynomial term accumulator
package spta_pkg;

    localparam int TableDepthDefault = 32;
    localparam int ExpW   = 13;
    localparam int CoeffW = 32;

    typedef enum logic [1:0] {
        OP_ACC   = 2'd0,
        OP_DRAIN = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_ZERO    = 3'd0,
        ST_MERGED  = 3'd1,
        ST_REMOVED = 3'd2,
        ST_APPEND  = 3'd3,
        ST_FULL    = 3'd4,
        ST_SAT     = 3'd5,
        ST_DRAINED = 3'd6,
        ST_CLEARED = 3'd7
    } status_t;

    typedef struct packed {
        logic signed [ExpW-1:0]   q;
        logic signed [ExpW-1:0]   t;
        logic signed [CoeffW-1:0] c;
    } term_t;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic  match_en;   // compare against key
        logic  remove;     // close up at the flagged cell
        logic  shift;      // drain rotation: take the right neighbor
        logic  load;       // write key at the tail cell
        term_t key;
    } cell_cmd_t;

endpackage

// ===== sv/spta_cell.sv =====
// one storage cell of the term chain: compare, merge write-back, close-up and rotate
module spta_cell
    import spta_pkg::*;
(
    input  logic      aclk,
    input  logic      is_tail,     // this cell is the first free slot
    input  logic      removing,    // at or after the cell being removed
    input  cell_cmd_t cmd,
    input  logic      merge_we,    // write back the merged coefficient
    input  logic signed [CoeffW-1:0] merge_c,
    input  term_t     right_term,
    output term_t     term,
    output logic      hit
);

    term_t term_reg;
    term_t term_next;

    assign term = term_reg;
    assign hit  = cmd.match_en && term_reg.q == cmd.key.q && term_reg.t == cmd.key.t;

    always_comb begin
        term_next = term_reg;
        if (cmd.shift || (cmd.remove && removing)) begin
            term_next = right_term;
        end else if (cmd.load && is_tail) begin
            term_next = cmd.key;
        end else if (merge_we) begin
            term_next.c = merge_c;
        end
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
    end

endmodule

// ===== sv/sparse_poly_term_accumulator.sv =====
// top level: command control, product stage and the chain of term cells
// an accumulate word passes S_MATCH and S_APPLY before the output register; a clear or empty
// drain loads the output register on acceptance; a new command is taken only in S_IDLE, after
// the last result word has been taken; a drain emits one word per cycle while the receiver takes
// them, as the stored terms rotate through the head cell; reset: synchronous active-low aresetn
// empties the table and idles control; cell contents stay undefined until written
module sparse_poly_term_accumulator
    import spta_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  logic        aclk,
    input  logic        aresetn,
    // op[1:0] q_exp_a[13:2] t_exp_a[25:14] coeff_a[41:26]
    // q_exp_b[53:42] t_exp_b[65:54] coeff_b[81:66], zero fill to 88
    input  logic [87:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[2:0] res_q_exp[15:3] res_t_exp[28:16] res_coeff[60:29]
    // term_valid[61] term_count[68:62], zero fill to 72
    output logic [71:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready
);

    localparam int CntW = $clog2(TABLE_DEPTH + 1);
    localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MATCH = 5'b00010,  // product registered, cells compare
        S_APPLY = 5'b00100,  // merge, remove or append
        S_DRAIN = 5'b01000,  // rotate chain, emit head each cycle the receiver allows
        S_OUT   = 5'b10000   // hold result word until taken
    } state_t;

    state_t state_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] drain_left_reg;
    term_t           key_reg;            // product term
    logic [IdxW-1:0] hit_idx_reg;
    logic            hit_any_reg;
    logic signed [CoeffW-1:0] hit_c_reg;

    // output register
    logic [2:0]              o_status_reg;
    term_t                   o_term_reg;
    logic                    o_valid_term_reg;
    logic                    o_last_reg;
    logic [CntW-1:0]         o_count_reg;
    logic                    m_tvalid_reg;

    // input field decode
    logic [1:0]               in_op;
    logic signed [11:0]       qa, ta, qb, tb;
    logic signed [15:0]       ca, cb;
    assign in_op = s_tdata[1:0];
    assign qa = s_tdata[13:2];
    assign ta = s_tdata[25:14];
    assign ca = s_tdata[41:26];
    assign qb = s_tdata[53:42];
    assign tb = s_tdata[65:54];
    assign cb = s_tdata[81:66];

    // chain of cells
    term_t     cell_term [TABLE_DEPTH];
    logic      cell_hit  [TABLE_DEPTH];
    cell_cmd_t cmd;
    logic signed [CoeffW:0] sum;
    logic signed [CoeffW-1:0] sum_sat;
    logic sat;
    logic out_load;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            term_t right;
            if (g == TABLE_DEPTH - 1) begin : g_end
                // drain rotation wraps the head around to the end
                assign right = cell_term[0];
            end else begin : g_mid
                // the last stored term takes the head so a drain rotates only stored terms
                assign right = (count_reg == CntW'(g + 1)) ? cell_term[0] : cell_term[g+1];
            end
            spta_cell u_cell (
                .aclk      (aclk),
                .is_tail   (count_reg == CntW'(g)),
                .removing  (hit_idx_reg <= IdxW'(g)),
                .cmd       (cmd),
                .merge_we  (state_reg == S_APPLY && hit_any_reg && sum_sat != '0
                            && hit_idx_reg == IdxW'(g)),
                .merge_c   (sum_sat),
                .right_term(right),
                .term      (cell_term[g]),
                .hit       (cell_hit[g])
            );
        end
    endgenerate

    // at most one cell can match since keys are unique
    logic [IdxW-1:0] hit_idx;
    logic            hit_any;
    logic signed [CoeffW-1:0] hit_c;
    always_comb begin
        hit_idx = '0;
        hit_any = 1'b0;
        hit_c   = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (cell_hit[i] && CntW'(i) < count_reg) begin
                hit_idx = IdxW'(i);
                hit_any = 1'b1;
                hit_c   = cell_term[i].c;
            end
        end
    end

    assign sum = {hit_c_reg[CoeffW-1], hit_c_reg} + {key_reg.c[CoeffW-1], key_reg.c};
    assign sat = sum[CoeffW] != sum[CoeffW-1];
    assign sum_sat = !sat ? sum[CoeffW-1:0]
                   : (sum[CoeffW] ? {1'b1, {(CoeffW-1){1'b0}}}
                                  : {1'b0, {(CoeffW-1){1'b1}}});

    logic full;
    assign full = count_reg == CntW'(TABLE_DEPTH);

    always_comb begin
        cmd          = '0;
        cmd.key      = key_reg;
        cmd.match_en = state_reg == S_MATCH;
        cmd.remove   = state_reg == S_APPLY && hit_any_reg && sum_sat == '0;
        cmd.load     = state_reg == S_APPLY && !hit_any_reg && !full;
        cmd.shift    = state_reg == S_DRAIN && (m_tready || !m_tvalid_reg);
    end

    // output register takes a new word
    assign out_load = (state_reg == S_IDLE && s_tvalid
                       && (op_t'(in_op) == OP_CLEAR
                           || (op_t'(in_op) == OP_DRAIN && count_reg == '0)))
                      || state_reg == S_APPLY || cmd.shift;

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b0, 7'(o_count_reg), o_valid_term_reg, o_term_reg.c,
                       o_term_reg.t, o_term_reg.q, o_status_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        key_reg.q <= ExpW'(qa) + ExpW'(qb);
                        key_reg.t <= ExpW'(ta) + ExpW'(tb);
                        key_reg.c <= CoeffW'(ca) * CoeffW'(cb);
                        unique case (op_t'(in_op))
                            OP_ACC:   state_reg <= S_MATCH;
                            OP_DRAIN: begin
                                drain_left_reg <= count_reg;
                                if (count_reg == '0) begin
                                    o_status_reg     <= ST_DRAINED;
                                    o_term_reg       <= '0;
                                    o_valid_term_reg <= 1'b0;
                                    o_last_reg       <= 1'b1;
                                    o_count_reg      <= count_reg;
                                    state_reg        <= S_OUT;
                                end else begin
                                    state_reg <= S_DRAIN;
                                end
                            end
                            OP_CLEAR: begin
                                count_reg        <= '0;
                                o_status_reg     <= ST_CLEARED;
                                o_term_reg       <= '0;
                                o_valid_term_reg <= 1'b0;
                                o_last_reg       <= 1'b1;
                                o_count_reg      <= '0;
                                state_reg        <= S_OUT;
                            end
                            OP_NONE:  state_reg <= S_IDLE;
                            default:  state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_MATCH: begin
                    hit_idx_reg <= hit_idx;
                    hit_any_reg <= hit_any;
                    hit_c_reg   <= hit_c;
                    state_reg   <= S_APPLY;
                end
                S_APPLY: begin
                    o_term_reg.q     <= key_reg.q;
                    o_term_reg.t     <= key_reg.t;
                    o_last_reg       <= 1'b1;
                    state_reg        <= S_OUT;
                    if (key_reg.c == '0) begin
                        o_status_reg     <= ST_ZERO;
                        o_term_reg.c     <= '0;
                        o_valid_term_reg <= 1'b0;
                        o_count_reg      <= count_reg;
                    end else if (hit_any_reg) begin
                        o_term_reg.c <= sum_sat;
                        if (sum_sat == '0) begin
                            o_status_reg     <= ST_REMOVED;
                            o_valid_term_reg <= 1'b0;
                            count_reg        <= count_reg - 1'b1;
                            o_count_reg      <= count_reg - 1'b1;
                        end else begin
                            o_status_reg     <= sat ? ST_SAT : ST_MERGED;
                            o_valid_term_reg <= 1'b1;
                            o_count_reg      <= count_reg;
                        end
                    end else if (full) begin
                        o_status_reg     <= ST_FULL;
                        o_term_reg.c     <= key_reg.c;
                        o_valid_term_reg <= 1'b0;
                        o_count_reg      <= count_reg;
                    end else begin
                        o_status_reg     <= ST_APPEND;
                        o_term_reg.c     <= key_reg.c;
                        o_valid_term_reg <= 1'b1;
                        count_reg        <= count_reg + 1'b1;
                        o_count_reg      <= count_reg + 1'b1;
                    end
                end
                S_DRAIN: begin
                    // head cell leaves; a rotation over the stored terms restores the order
                    if (cmd.shift) begin
                        o_status_reg     <= ST_DRAINED;
                        o_term_reg       <= cell_term[0];
                        o_valid_term_reg <= 1'b1;
                        o_last_reg       <= drain_left_reg == CntW'(1);
                        o_count_reg      <= count_reg;
                        drain_left_reg   <= drain_left_reg - 1'b1;
                        if (drain_left_reg == CntW'(1)) begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the sparse polynomial term accumulator
`timescale 1ns / 100ps

module tb_top;
    import spta_pkg::*;

    localparam int Depth      = 32;
    localparam int StallLimit = 20000;

    // one expected output word
    typedef struct {
        status_t         st;
        logic [12:0]     q;
        logic [12:0]     t;
        logic [31:0]     c;
        logic            tv;
        logic            lst;
        logic [6:0]      cnt;
    } word_t;

    // keeps its own copy of the term table and predicts every word
    class term_scoreboard;
        logic signed [12:0] tq[Depth];
        logic signed [12:0] tt[Depth];
        logic signed [31:0] tc[Depth];
        int                 n_terms;
        word_t              pending[$];
        int                 errors;

        function new();
            n_terms = 0;
            errors  = 0;
        endfunction

        function void push(status_t st, logic [12:0] q, logic [12:0] t, logic [31:0] c,
                           logic tv, logic lst);
            word_t w;
            w.st = st; w.q = q; w.t = t; w.c = c; w.tv = tv; w.lst = lst;
            w.cnt = 7'(n_terms);
            pending.push_back(w);
        endfunction

        // note an accepted input word and queue its results
        function void note_input(logic [87:0] d);
            op_t                op;
            logic signed [12:0] q, t;
            longint             c, s;
            int                 hit;
            op = op_t'(d[1:0]);
            q  = 13'($signed(d[13:2])) + 13'($signed(d[53:42]));
            t  = 13'($signed(d[25:14])) + 13'($signed(d[65:54]));
            c  = longint'($signed(d[41:26])) * longint'($signed(d[81:66]));
            case (op)
                OP_ACC: begin
                    hit = -1;
                    for (int i = 0; i < n_terms; i++)
                        if (hit < 0 && tq[i] == q && tt[i] == t) hit = i;
                    if (c == 0) begin
                        push(ST_ZERO, q, t, 0, 0, 1);
                    end else if (hit >= 0) begin
                        s = longint'(tc[hit]) + c;
                        if (s == 0) begin
                            for (int j = hit; j + 1 < n_terms; j++) begin
                                tq[j] = tq[j+1]; tt[j] = tt[j+1]; tc[j] = tc[j+1];
                            end
                            n_terms--;
                            push(ST_REMOVED, q, t, 0, 0, 1);
                        end else if (s > 64'sd2147483647) begin
                            tc[hit] = 32'h7fffffff;
                            push(ST_SAT, q, t, tc[hit], 1, 1);
                        end else if (s < -64'sd2147483648) begin
                            tc[hit] = 32'h80000000;
                            push(ST_SAT, q, t, tc[hit], 1, 1);
                        end else begin
                            tc[hit] = 32'(s);
                            push(ST_MERGED, q, t, tc[hit], 1, 1);
                        end
                    end else if (n_terms >= Depth) begin
                        push(ST_FULL, q, t, 32'(c), 0, 1);
                    end else begin
                        tq[n_terms] = q; tt[n_terms] = t; tc[n_terms] = 32'(c);
                        n_terms++;
                        push(ST_APPEND, q, t, 32'(c), 1, 1);
                    end
                end
                OP_DRAIN: begin
                    if (n_terms == 0) push(ST_DRAINED, 0, 0, 0, 0, 1);
                    for (int i = 0; i < n_terms; i++)
                        push(ST_DRAINED, tq[i], tt[i], tc[i], 1, i == n_terms - 1);
                end
                OP_CLEAR: begin
                    n_terms = 0;
                    push(ST_CLEARED, 0, 0, 0, 0, 1);
                end
                default: ;
            endcase
        endfunction

        // compare an accepted output word with the oldest expectation
        function void check_output(logic [71:0] d, logic lst);
            word_t w;
            if (pending.size() == 0) begin
                $error("unexpected word %h", d);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (d[2:0] != w.st) begin
                $error("status exp %0d got %0d", w.st, d[2:0]); errors++;
            end
            if (d[15:3] != w.q) begin
                $error("res_q_exp exp %0d got %0d", $signed(w.q), $signed(d[15:3])); errors++;
            end
            if (d[28:16] != w.t) begin
                $error("res_t_exp exp %0d got %0d", $signed(w.t), $signed(d[28:16])); errors++;
            end
            if (d[60:29] != w.c) begin
                $error("res_coeff exp %0d got %0d", $signed(w.c), $signed(d[60:29])); errors++;
            end
            if (d[61] != w.tv) begin
                $error("term_valid exp %0d got %0d", w.tv, d[61]); errors++;
            end
            if (lst != w.lst) begin
                $error("last exp %0d got %0d", w.lst, lst); errors++;
            end
            if (d[68:62] != w.cnt) begin
                $error("term_count exp %0d got %0d", w.cnt, d[68:62]); errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic [87:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;

    term_scoreboard sb;
    bit             hold_sink;    // long receiver hold-off request
    int             quiet_cycles;

    sparse_poly_term_accumulator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // small pool of exponents so that products often collide
    function automatic logic [11:0] pick_exp();
        if ($urandom_range(0, 9) < 8) return 12'($urandom_range(0, 3));
        return 12'($urandom);
    endfunction

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 1) ? 1 : -1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [87:0] pack_word(op_t op, logic [11:0] qa, logic [11:0] ta,
                                             logic [15:0] ca, logic [11:0] qb,
                                             logic [11:0] tb, logic [15:0] cb);
        return {6'b0, cb, tb, qb, ca, ta, qa, op};
    endfunction

    // offer one word after a random gap, wait for its handshake
    task automatic send_word(logic [87:0] d);
        int gap;
        gap = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(d);
    endtask

    task automatic send_acc(logic [11:0] qa, logic [11:0] ta, logic [15:0] ca,
                            logic [11:0] qb, logic [11:0] tb, logic [15:0] cb);
        send_word(pack_word(OP_ACC, qa, ta, ca, qb, tb, cb));
    endtask

    task automatic send_cmd(op_t op);
        send_word(pack_word(op, 12'($urandom), 12'($urandom), 16'($urandom),
                            12'($urandom), 12'($urandom), 16'($urandom)));
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (60) @(posedge aclk);
                hold_sink = 0;
            end
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            sb.check_output(m_tdata, m_tlast);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > StallLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        sb           = new();
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        aresetn      = 1'b0;
        quiet_cycles = 0;
        hold_sink    = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty drain, extremes, zero product, merge, removal, saturation
        send_cmd(OP_DRAIN);
        send_acc(12'h800, 12'h800, 16'h8000, 12'h800, 12'h800, 16'h8000);
        send_acc(12'h7ff, 12'h7ff, 16'h7fff, 12'h7ff, 12'h7ff, 16'h7fff);
        send_acc(12'h001, 12'h002, 16'h0000, 12'h000, 12'h000, 16'h0001);
        send_acc(12'h001, 12'h002, 16'h0005, 12'h000, 12'h000, 16'h0001);
        send_acc(12'h001, 12'h002, 16'h0003, 12'h000, 12'h000, 16'h0001);
        send_acc(12'h001, 12'h002, 16'hfff8, 12'h000, 12'h000, 16'h0001);
        send_acc(12'h800, 12'h800, 16'h8000, 12'h800, 12'h800, 16'h8000);
        send_acc(12'h7ff, 12'h7ff, 16'h8000, 12'h7ff, 12'h7ff, 16'h7fff);
        send_acc(12'h7ff, 12'h7ff, 16'h8000, 12'h7ff, 12'h7ff, 16'h7fff);
        send_acc(12'h7ff, 12'h7ff, 16'h8000, 12'h7ff, 12'h7ff, 16'h7fff);
        send_acc(12'h7ff, 12'h7ff, 16'h8000, 12'h7ff, 12'h7ff, 16'h7fff);
        send_cmd(OP_NONE);
        send_cmd(OP_DRAIN);
        send_cmd(OP_CLEAR);

        // fill past the depth, with the receiver held off to back up the block
        hold_sink = 1;
        for (int i = 0; i < Depth + 3; i++)
            send_acc(12'(i), 12'(i >> 2), 16'(i + 1), 12'h000, 12'h000, 16'h0001);
        send_cmd(OP_DRAIN);
        send_acc(12'h000, 12'h000, 16'hffff, 12'h000, 12'h000, 16'h0001);
        send_acc(12'h000, 12'h000, 16'h0007, 12'h000, 12'h000, 16'h0001);
        send_cmd(OP_DRAIN);
        send_cmd(OP_CLEAR);

        // random: mostly accumulates on a small exponent set, some drains and clears
        for (int k = 0; k < 264; k++) begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 8)        send_cmd(OP_DRAIN);
            else if (r < 10)  send_cmd(OP_CLEAR);
            else if (r < 12)  send_cmd(OP_NONE);
            else if (r < 30)
                send_acc(pick_exp(), pick_exp(), pick_coeff(), 12'h000, 12'h000, 16'h0001);
            else
                send_acc(pick_exp(), pick_exp(), pick_coeff(), pick_exp(), pick_exp(),
                         pick_coeff());
        end
        send_cmd(OP_DRAIN);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
